/* rtl/bfpa_pkg.sv */
// ----------------------------------------------------------------------------
// bfpa_pkg
// shared constants, item types and the page count helper for the best-fit
// page allocator
// ----------------------------------------------------------------------------
package bfpa_pkg;

	localparam int PAGES        = 1024;
	localparam int PAGE_BYTES   = 4096;
	localparam int HEADER_BYTES = 24;

	localparam int PAGE_W     = $clog2(PAGES);
	localparam int CNT_W      = $clog2(PAGES + 1);
	localparam int TAG_W      = 8;
	localparam int BYTE_W     = 32;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	// quotient of a 33-bit sum plus room for the extra pages
	localparam int NEED_W     = BYTE_W + 2 - PAGE_SHIFT;

	localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(PAGES - 1);

	// command codes
	localparam logic [1:0] CMD_SET           = 2'd0;
	localparam logic [1:0] CMD_ALLOC         = 2'd1;
	localparam logic [1:0] CMD_ALLOC_ALIGNED = 2'd2;
	localparam logic [1:0] CMD_FREE          = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	typedef struct packed {
		logic [1:0]        command;
		logic [PAGE_W-1:0] page_index;
		logic [TAG_W-1:0]  region_id;
		logic [BYTE_W-1:0] byte_size;
		logic [CNT_W-1:0]  page_count;
	} bfpa_cmd_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [PAGE_W-1:0] start_page;
		logic [CNT_W-1:0]  pages_taken;
		logic [CNT_W-1:0]  free_total;
	} bfpa_res_t;

	// controls from the sequencer to the run scanner
	typedef struct packed {
		logic start;
		logic page_vld;
		logic flush;
	} bfpa_scan_ctl_t;

	// best fit found by the run scanner
	typedef struct packed {
		logic              found;
		logic [PAGE_W-1:0] start;
	} bfpa_fit_t;

	// (size + header) / page size + 1, or + 2 when aligned; zero size gives the extra alone
	function automatic logic [NEED_W-1:0] pages_needed(input logic [BYTE_W-1:0] bytes,
			input logic aligned);
		logic [BYTE_W:0]   sum;
		logic [NEED_W-1:0] extra;
		sum   = {1'b0, bytes} + (BYTE_W + 1)'(HEADER_BYTES);
		extra = aligned ? NEED_W'(2) : NEED_W'(1);
		if (bytes == '0) begin
			return extra;
		end
		return NEED_W'(sum >> PAGE_SHIFT) + extra;
	endfunction

endpackage

/* rtl/bfpa_ram.sv */
// ----------------------------------------------------------------------------
// bfpa_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bfpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* rtl/bfpa_run_scan.sv */
// ----------------------------------------------------------------------------
// bfpa_run_scan
// run tracker and best-fit compare, fed one page per cycle
// ----------------------------------------------------------------------------
module bfpa_run_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bfpa_pkg::bfpa_scan_ctl_t      ctl,
	input  logic [bfpa_pkg::PAGE_W-1:0]   page_addr,
	input  logic                          page_free,
	input  logic [bfpa_pkg::TAG_W-1:0]    page_tag,
	input  logic [bfpa_pkg::NEED_W-1:0]   need,
	output bfpa_pkg::bfpa_fit_t           fit
);
	import bfpa_pkg::*;

	logic              in_run_q;
	logic              found_q;
	logic [PAGE_W-1:0] cur_start_q;
	logic [CNT_W-1:0]  cur_len_q;
	logic [TAG_W-1:0]  cur_tag_q;
	logic [PAGE_W-1:0] best_start_q;
	logic [CNT_W-1:0]  best_len_q;

	logic extend;
	logic close;
	logic better;

	// page continues the open run only when free with the same tag
	assign extend = in_run_q && ctl.page_vld && page_free && (page_tag == cur_tag_q);
	assign close  = in_run_q && (ctl.flush || (ctl.page_vld && !extend));
	assign better = close && (NEED_W'(cur_len_q) >= need) &&
		(!found_q || (cur_len_q < best_len_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q <= 1'b0;
			found_q  <= 1'b0;
		end else if (ctl.start) begin
			in_run_q <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			if (better) begin
				found_q <= 1'b1;
			end
			if (ctl.page_vld) begin
				in_run_q <= page_free;
			end
			if (ctl.flush) begin
				in_run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (better) begin
			best_start_q <= cur_start_q;
			best_len_q   <= cur_len_q;
		end
		if (extend) begin
			cur_len_q <= cur_len_q + 1'b1;
		end else if (ctl.page_vld && page_free) begin
			cur_start_q <= page_addr;
			cur_len_q   <= CNT_W'(1);
			cur_tag_q   <= page_tag;
		end
	end

	assign fit.found = found_q;
	assign fit.start = best_start_q;

endmodule

/* rtl/best_fit_page_allocator_core.sv */
// ----------------------------------------------------------------------------
// best_fit_page_allocator_core: best-fit contiguous page allocator
// set reads and then writes its page, free walks page_count pages, allocate
// scans every page and marks the granted run (no marking with no fit); a bad or empty free skips the walk
// one item at a time, ready again in the same cycle that the result is raised
// after reset a clearing pass zeroes the page store, no item taken
// ----------------------------------------------------------------------------
module best_fit_page_allocator_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  bfpa_pkg::bfpa_cmd_t   cmd,
	output logic                  res_valid,
	input  logic                  res_ready,
	output bfpa_pkg::bfpa_res_t   res
);
	import bfpa_pkg::*;

	// sequencer states
	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_SET_RD   = 4'd2;
	localparam logic [3:0] S_SET_WR   = 4'd3;
	localparam logic [3:0] S_FREE     = 4'd4;
	localparam logic [3:0] S_FREE_END = 4'd5;
	localparam logic [3:0] S_SCAN     = 4'd6;
	localparam logic [3:0] S_DRAIN    = 4'd7;
	localparam logic [3:0] S_FLUSH    = 4'd8;
	localparam logic [3:0] S_PICK     = 4'd9;
	localparam logic [3:0] S_MARK     = 4'd10;
	localparam logic [3:0] S_DONE     = 4'd11;

	logic [3:0]        state_q;
	logic [PAGE_W-1:0] ptr_q;       // page walked by clear, scan, free and mark
	logic [CNT_W-1:0]  rem_q;       // pages still to walk in free and mark
	logic [CNT_W-1:0]  total_q;     // running count of free pages
	logic              res_valid_q;
	logic              scan_vld_s1; // page read for the scan is on the ram output
	logic              free_vld_s1; // page read for a free is on the ram output
	logic [PAGE_W-1:0] addr_s1;     // address of the page on the ram output

	logic [TAG_W-1:0]  region_q;
	logic [NEED_W-1:0] need_q;
	logic [1:0]        status_q;
	logic [PAGE_W-1:0] start_q;
	logic [CNT_W-1:0]  taken_q;
	bfpa_res_t         res_q;

	// page store ports
	logic              free_we;
	logic [PAGE_W-1:0] free_waddr;
	logic              free_wdata;
	logic              free_rdata;
	logic              tag_we;
	logic [TAG_W-1:0]  tag_wdata;
	logic [TAG_W-1:0]  tag_rdata;

	logic              set_bad;
	logic              free_bad;
	logic              is_alloc;
	logic              res_slot;
	bfpa_scan_ctl_t    scan_ctl;
	bfpa_fit_t         fit;

	// range checks on the incoming item
	assign set_bad  = CNT_W'(cmd.page_index) >= CNT_W'(PAGES);
	assign free_bad = ((CNT_W + 1)'(cmd.page_index) + (CNT_W + 1)'(cmd.page_count))
		> (CNT_W + 1)'(PAGES);
	assign is_alloc = (cmd.command == CMD_ALLOC) || (cmd.command == CMD_ALLOC_ALIGNED);

	// output register is free or being emptied this cycle
	assign res_slot = !res_valid_q || res_ready;

	assign cmd_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// page store: free bits and region tags side by side, same read address
	bfpa_ram #(
		.WIDTH (1),
		.DEPTH (PAGES)
	) u_free_ram (
		.clk   (clk),
		.we    (free_we),
		.waddr (free_waddr),
		.wdata (free_wdata),
		.raddr (ptr_q),
		.rdata (free_rdata)
	);

	bfpa_ram #(
		.WIDTH (TAG_W),
		.DEPTH (PAGES)
	) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (ptr_q),
		.wdata (tag_wdata),
		.raddr (ptr_q),
		.rdata (tag_rdata)
	);

	// run tracker sees one page per cycle during the scan, then a flush
	assign scan_ctl.start    = cmd_valid && cmd_ready && is_alloc;
	assign scan_ctl.page_vld = scan_vld_s1;
	assign scan_ctl.flush    = (state_q == S_FLUSH);

	bfpa_run_scan u_run_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.page_addr (addr_s1),
		.page_free (free_rdata),
		.page_tag  (tag_rdata),
		.need      (need_q),
		.fit       (fit)
	);

	// write side of the page store
	always_comb begin
		free_we    = 1'b0;
		free_waddr = ptr_q;
		free_wdata = 1'b0;
		tag_we     = 1'b0;
		tag_wdata  = region_q;
		if (state_q == S_CLEAR) begin
			// reset pass: not free, tag zero
			free_we   = 1'b1;
			tag_we    = 1'b1;
			tag_wdata = '0;
		end else if (state_q == S_SET_WR) begin
			free_we    = 1'b1;
			free_wdata = 1'b1;
			tag_we     = 1'b1;
		end else if (state_q == S_MARK) begin
			// leading pages of the granted run go used
			free_we = 1'b1;
		end else if (free_vld_s1) begin
			// free: write back behind the read, to the page now on the ram output
			free_we    = 1'b1;
			free_waddr = addr_s1;
			free_wdata = 1'b1;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			ptr_q       <= '0;
			rem_q       <= '0;
			total_q     <= '0;
			res_valid_q <= 1'b0;
			scan_vld_s1 <= 1'b0;
			free_vld_s1 <= 1'b0;
		end else begin
			scan_vld_s1 <= (state_q == S_SCAN);
			free_vld_s1 <= (state_q == S_FREE);
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			// a page that was used turns free: count it once
			if (free_vld_s1 && !free_rdata) begin
				total_q <= total_q + 1'b1;
			end
			unique case (state_q)
				S_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST_PAGE) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.command) inside
							CMD_SET: begin
								ptr_q   <= cmd.page_index;
								state_q <= set_bad ? S_DONE : S_SET_RD;
							end
							CMD_FREE: begin
								ptr_q   <= cmd.page_index;
								rem_q   <= cmd.page_count;
								state_q <= (free_bad || (cmd.page_count == '0)) ?
									S_DONE : S_FREE;
							end
							CMD_ALLOC, CMD_ALLOC_ALIGNED: begin
								ptr_q   <= '0;
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SET_RD: begin
					state_q <= S_SET_WR;
				end
				S_SET_WR: begin
					if (!free_rdata) begin
						total_q <= total_q + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_FREE: begin
					ptr_q <= ptr_q + 1'b1;
					rem_q <= rem_q - 1'b1;
					if (rem_q == CNT_W'(1)) begin
						state_q <= S_FREE_END;
					end
				end
				S_FREE_END: begin
					state_q <= S_DONE;
				end
				S_SCAN: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST_PAGE) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FLUSH;
				end
				S_FLUSH: begin
					state_q <= S_PICK;
				end
				S_PICK: begin
					if (fit.found) begin
						// need fits in the count width since it is at most the run length
						ptr_q   <= fit.start;
						rem_q   <= CNT_W'(need_q);
						total_q <= total_q - CNT_W'(need_q);
						state_q <= S_MARK;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_MARK: begin
					ptr_q <= ptr_q + 1'b1;
					rem_q <= rem_q - 1'b1;
					if (rem_q == CNT_W'(1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_slot) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item payload and result fields
	always_ff @(posedge clk) begin
		addr_s1 <= ptr_q;
		if (cmd_valid && cmd_ready) begin
			region_q <= cmd.region_id;
			need_q   <= pages_needed(cmd.byte_size, cmd.command == CMD_ALLOC_ALIGNED);
			start_q  <= '0;
			taken_q  <= '0;
			if (cmd.command == CMD_SET) begin
				status_q <= set_bad ? ST_INVALID : ST_OK;
			end else if (cmd.command == CMD_FREE) begin
				status_q <= free_bad ? ST_INVALID : ST_OK;
			end else begin
				status_q <= ST_NOFIT;
			end
		end
		if (state_q == S_PICK && fit.found) begin
			status_q <= ST_OK;
			start_q  <= fit.start;
			taken_q  <= CNT_W'(need_q);
		end
		if (state_q == S_DONE && res_slot) begin
			res_q.status      <= status_q;
			res_q.start_page  <= start_q;
			res_q.pages_taken <= taken_q;
			res_q.free_total  <= total_q;
		end
	end

`ifndef SYNTHESIS
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(PAGES))
		else $error("free page count above page total");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.status != ST_OK)) |->
		((res.pages_taken == '0) && (res.start_page == '0)))
		else $error("failed item reports a grant");

	a_mark_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK) |-> fit.found)
		else $error("marking pages without a fitting run");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready)
		else $error("item taken while previous item in work");
`endif

endmodule

/* sim/bfpa_checker.sv */
// ----------------------------------------------------------------------------
// bfpa_checker
// watches both channels of the page allocator, keeps its own free map, tag
// store and free count, and compares every result with the oldest outcome
// ----------------------------------------------------------------------------
module bfpa_checker
	import bfpa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  logic      cmd_ready,
	input  bfpa_cmd_t cmd,
	input  logic      res_valid,
	input  logic      res_ready,
	input  bfpa_res_t res,
	output int        n_fail,
	output int        n_waiting
);

	logic             page_is_free [PAGES];
	logic [TAG_W-1:0] page_tag     [PAGES];
	int               free_count;
	bfpa_res_t        outcome_q[$];
	bfpa_res_t        want;
	int               fail_tally;

	// size plus header over page size, plus one or two, zero size gives the extra
	function automatic longint unsigned pages_for_bytes(input logic [BYTE_W-1:0] bytes,
			input logic aligned);
		longint unsigned extra;
		extra = aligned ? 2 : 1;
		if (bytes == '0) begin
			return extra;
		end
		return (longint'(bytes) + HEADER_BYTES) / PAGE_BYTES + extra;
	endfunction

	// applies one item to the page state and returns the result it causes
	function automatic bfpa_res_t page_cmd_outcome(input bfpa_cmd_t c);
		bfpa_res_t        r;
		longint unsigned  need;
		int               p;
		int               run_start;
		int               best_start;
		int               best_len;
		logic [TAG_W-1:0] run_tag;
		r = '0;
		r.status = ST_OK;
		case (c.command)
			CMD_SET: begin
				page_tag[c.page_index] = c.region_id;
				if (!page_is_free[c.page_index]) begin
					page_is_free[c.page_index] = 1'b1;
					free_count++;
				end
			end
			CMD_FREE: begin
				if (int'(c.page_index) + int'(c.page_count) > PAGES) begin
					r.status = ST_INVALID;
				end else begin
					for (p = int'(c.page_index); p < int'(c.page_index) + int'(c.page_count); p++) begin
						if (!page_is_free[p]) begin
							page_is_free[p] = 1'b1;
							free_count++;
						end
					end
				end
			end
			default: begin
				need = pages_for_bytes(c.byte_size, c.command == CMD_ALLOC_ALIGNED);
				best_start = 0;
				best_len = 0;
				p = 0;
				// walk the runs, each one ends at a used page, a tag change or the end
				while (p < PAGES) begin
					if (!page_is_free[p]) begin
						p++;
					end else begin
						run_start = p;
						run_tag = page_tag[p];
						while (p < PAGES && page_is_free[p] && page_tag[p] == run_tag) begin
							p++;
						end
						// strict less keeps the first run on a tie
						if (longint'(p - run_start) >= need &&
								(best_len == 0 || p - run_start < best_len)) begin
							best_start = run_start;
							best_len = p - run_start;
						end
					end
				end
				if (best_len == 0) begin
					r.status = ST_NOFIT;
				end else begin
					for (p = best_start; p < best_start + int'(need); p++) begin
						page_is_free[p] = 1'b0;
					end
					free_count -= int'(need);
					r.start_page = PAGE_W'(best_start);
					r.pages_taken = CNT_W'(need);
				end
			end
		endcase
		r.free_total = CNT_W'(free_count);
		return r;
	endfunction

	task automatic compare_field(input string name, input int unsigned exp_val,
			input int unsigned got_val);
		if (exp_val != got_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			fail_tally++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PAGES; p++) begin
				page_is_free[p] = 1'b0;
				page_tag[p] = '0;
			end
			free_count = 0;
			outcome_q.delete();
			n_waiting <= 0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				outcome_q.push_back(page_cmd_outcome(cmd));
			end
			if (res_valid && res_ready) begin
				if (outcome_q.size() == 0) begin
					$error("result with no item pending: status %0d start_page %0d",
						res.status, res.start_page);
					fail_tally++;
				end else begin
					want = outcome_q.pop_front();
					compare_field("status", want.status, res.status);
					compare_field("start_page", want.start_page, res.start_page);
					compare_field("pages_taken", want.pages_taken, res.pages_taken);
					compare_field("free_total", want.free_total, res.free_total);
				end
			end
			n_waiting <= outcome_q.size();
			n_fail <= fail_tally;
		end
	end

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// drives the page allocator with directed and random commands under several
// idle and stall mixes, the checker beside the block judges every result
// ----------------------------------------------------------------------------
module tb_top;
	import bfpa_pkg::*;

	localparam int RANDOM_PER_PHASE = 137;
	localparam int HOLD_CYCLES      = 3000;
	// worst item: full scan plus the whole map marked, with margin
	localparam int TAIL_CYCLES      = 2 * PAGES + 16;
	localparam int MAX_CYCLES       = 8_000_000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	bfpa_cmd_t cmd = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	bfpa_res_t res;

	int n_fail;
	int n_waiting;
	int idle_pct = 0;
	int stall_pct = 0;
	logic hold_req = 1'b0;
	int cycle_count = 0;

	best_fit_page_allocator_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	bfpa_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.n_fail    (n_fail),
		.n_waiting (n_waiting)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// safety net, far above the slowest correct run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= MAX_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: random stalls, or one long hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			res_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic bfpa_cmd_t make_cmd(input logic [1:0] op, input int idx,
			input int tag, input logic [BYTE_W-1:0] bytes, input int cnt);
		bfpa_cmd_t c;
		c.command = op;
		c.page_index = PAGE_W'(idx);
		c.region_id = TAG_W'(tag);
		c.byte_size = bytes;
		c.page_count = CNT_W'(cnt);
		return c;
	endfunction

	// mostly well-formed traffic: small allocations, frees that fit, a few tags,
	// with occasional huge sizes, frees past the end and whole-map refills
	function automatic bfpa_cmd_t random_page_cmd();
		bfpa_cmd_t   c;
		int unsigned pick;
		int unsigned sub;
		c.page_index = PAGE_W'($urandom);
		c.region_id = ($urandom_range(9) == 0) ? TAG_W'($urandom) : TAG_W'($urandom_range(3));
		c.byte_size = BYTE_W'($urandom);
		c.page_count = CNT_W'($urandom);
		pick = $urandom_range(99);
		sub = $urandom_range(19);
		if (pick < 30) begin
			c.command = CMD_SET;
		end else if (pick < 55) begin
			c.command = CMD_FREE;
			if (sub == 0) begin
				c.page_index = '0;
				c.page_count = CNT_W'(PAGES);
			end else if (sub < 17) begin
				c.page_count = CNT_W'($urandom_range(64));
				if (int'(c.page_index) + int'(c.page_count) > PAGES) begin
					c.page_index = PAGE_W'(PAGES - int'(c.page_count));
				end
			end
		end else begin
			c.command = (pick < 85) ? CMD_ALLOC : CMD_ALLOC_ALIGNED;
			if (sub < 15) begin
				c.byte_size = BYTE_W'($urandom_range(40000));
			end else if (sub < 18) begin
				// just below, on and just above a page boundary
				c.byte_size = BYTE_W'($urandom_range(16, 1) * PAGE_BYTES - HEADER_BYTES - 1 +
					$urandom_range(2));
			end
		end
		return c;
	endfunction

	// valid stays high across back-to-back items, it only drops for a gap
	task automatic push_cmd(input bfpa_cmd_t c);
		while ($urandom_range(99) < idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!cmd_ready);
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (n_waiting != 0) @(posedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty map, extremes, rewrites, bad frees, full map, ties
		push_cmd(make_cmd(CMD_ALLOC, 0, 0, 32'd0, 0));
		push_cmd(make_cmd(CMD_ALLOC_ALIGNED, 0, 0, 32'hFFFF_FFFF, 0));
		push_cmd(make_cmd(CMD_SET, 1023, 8'hFF, 32'd0, 0));
		push_cmd(make_cmd(CMD_SET, 1023, 8'h80, 32'd0, 0));
		push_cmd(make_cmd(CMD_FREE, 0, 0, 32'd0, 0));
		push_cmd(make_cmd(CMD_FREE, 1000, 0, 32'd0, 25));
		push_cmd(make_cmd(CMD_FREE, 1023, 0, 32'd0, 2047));
		push_cmd(make_cmd(CMD_FREE, 0, 0, 32'd0, PAGES));
		push_cmd(make_cmd(CMD_FREE, 5, 0, 32'd0, 10));
		push_cmd(make_cmd(CMD_ALLOC, 0, 0, 32'd0, 0));
		push_cmd(make_cmd(CMD_ALLOC_ALIGNED, 0, 0, 32'd0, 0));
		push_cmd(make_cmd(CMD_ALLOC, 0, 0, 32'hFFFF_FFFF, 0));
		push_cmd(make_cmd(CMD_FREE, 0, 0, 32'd0, PAGES));
		push_cmd(make_cmd(CMD_SET, 1023, 0, 32'd0, 0));
		// exactly the whole map
		push_cmd(make_cmd(CMD_ALLOC, 0, 0, BYTE_W'((PAGES - 1) * PAGE_BYTES - HEADER_BYTES), 0));
		push_cmd(make_cmd(CMD_ALLOC, 0, 0, 32'd0, 0));
		push_cmd(make_cmd(CMD_FREE, 1023, 0, 32'd0, 1));
		push_cmd(make_cmd(CMD_FREE, 0, 0, 32'd0, 1023));
		// two equal tagged runs inside one big free area
		push_cmd(make_cmd(CMD_SET, 100, 5, 32'd0, 0));
		push_cmd(make_cmd(CMD_SET, 101, 5, 32'd0, 0));
		push_cmd(make_cmd(CMD_SET, 200, 5, 32'd0, 0));
		push_cmd(make_cmd(CMD_SET, 201, 5, 32'd0, 0));
		push_cmd(make_cmd(CMD_ALLOC_ALIGNED, 0, 0, 32'd0, 0));
		push_cmd(make_cmd(CMD_ALLOC, 0, 0, BYTE_W'(PAGE_BYTES - HEADER_BYTES - 1), 0));
		push_cmd(make_cmd(CMD_ALLOC, 0, 0, BYTE_W'(PAGE_BYTES - HEADER_BYTES), 0));
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 69; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 69; end
				default: begin idle_pct = 24; stall_pct = 24; end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				push_cmd(random_page_cmd());
			end
			if (phase == 0) begin
				// long receiver hold-off while items keep coming, input must stall
				hold_req = 1'b1;
				for (int n = 0; n < 8; n++) begin
					push_cmd(make_cmd(CMD_SET, $urandom_range(PAGES - 1), $urandom_range(3),
						BYTE_W'($urandom), $urandom_range(2047)));
				end
			end
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_fail == 0 && n_waiting == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
